### rtl/core/qers_pkg.sv
// Package: types, codes and constants of the queue engine.
package qers_pkg;

  localparam int DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_ROTATE = 3'd2,
    OP_SORT   = 3'd3,
    OP_CUT    = 3'd4
  } opcode_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pop_value;
    logic [1:0]  status;
    logic [4:0]  occupancy;
    logic        is_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP,
    S_ROT,
    S_SUM_RD,
    S_SUM_ADD,
    S_DIV,
    S_AVG_WR,
    S_PAIR_RD,
    S_PAIR_CMP,
    S_PAIR_WR,
    S_DONE
  } state_t;

endpackage

### rtl/core/queue_engine_with_rotate_sort.sv
// Top level: bounded queue engine with rotate, sort and cut-and-replace.
// Result valid in S_DONE: push and no-op cases come from S_DISPATCH, pop/rotate via S_POP/S_ROT.
// Sort: bubble passes over the ring, S_PAIR_RD and S_PAIR_CMP per compare plus S_PAIR_WR per swap,
// n*(n-1)/2 compares. Cut: S_PAIR_RD, S_PAIR_CMP and S_PAIR_WR per swap over n/2 + n/4 swaps,
// plus S_SUM_RD and S_SUM_ADD per entry of sum and a 32+CW step divide (37 at 16 deep) when n is odd.
// One item at a time: ready again in the cycle after the result is taken. Reset empties the queue.
module queue_engine_with_rotate_sort #(
  parameter int DEPTH = qers_pkg::DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  qers_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output qers_pkg::out_item_t out_data
);
  import qers_pkg::*;

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = 32 + CW;
  localparam int DCW = $clog2(SW);

  logic [31:0] ring [DEPTH];

  state_t         state, state_next;
  logic [AW-1:0]  head;
  logic [CW-1:0]  count;
  logic [2:0]     op;
  logic [31:0]    pval;
  logic [31:0]    pop_word;
  logic [1:0]     status_code;
  logic [CW-1:0]  pa;
  logic [CW-1:0]  pb;
  logic [CW-1:0]  last;
  logic           phase;
  logic [31:0]    tmp;
  logic [SW-1:0]  sum;
  logic [CW-1:0]  rem;
  logic [DCW-1:0] dcnt;
  logic [31:0]    rd_a;
  logic [31:0]    rd_b;

  logic [AW-1:0]  addr_a;
  logic [AW-1:0]  addr_b;
  logic [AW-1:0]  waddr;
  logic           we;
  logic [31:0]    wdata;
  logic [AW-1:0]  head_inc;
  logic [AW-1:0]  head_dec;
  logic           is_sort;
  logic           swap_hit;
  logic           pass_end;
  logic           rev_more;
  logic           cut_p1_go;
  logic           pair_last;
  logic           step;
  logic           sum_last;
  logic [CW:0]    rem_sh;
  logic [CW:0]    rem_diff;
  logic           qbit;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] h, input logic [CW-1:0] p);
    logic [CW:0] v;
    v = (CW+1)'(h) + (CW+1)'(p);
    if (v >= (CW+1)'(DEPTH)) v = v - (CW+1)'(DEPTH);
    return v[AW-1:0];
  endfunction

  assign head_inc = slot_of(head, CW'(1));
  assign head_dec = slot_of(head, CW'(DEPTH - 1));

  assign is_sort   = (op == OP_SORT);
  assign swap_hit  = is_sort ? (rd_a > rd_b) : 1'b1;
  assign pass_end  = ({1'b0, pa} + (CW+1)'(1)) >= {1'b0, last};
  assign rev_more  = ({1'b0, pa} + (CW+1)'(2)) < {1'b0, pb};
  assign cut_p1_go = ({1'b0, count >> 1} + (CW+1)'(1)) < {1'b0, count};
  assign pair_last = is_sort ? (pass_end && (last <= CW'(1))) :
                     phase   ? !rev_more : (!rev_more && !cut_p1_go);
  assign step      = ((state == S_PAIR_CMP) && !swap_hit) || (state == S_PAIR_WR);
  assign sum_last  = ((pa + CW'(1)) == count);

  // restoring divide: dividend shifts out of sum, quotient bits shift in
  assign rem_sh   = {rem, sum[SW-1]};
  assign rem_diff = rem_sh - {1'b0, count};
  assign qbit     = (rem_sh >= {1'b0, count});

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DISPATCH;
      end
      S_DISPATCH: begin
        state_next = S_DONE;
        case (op)
          OP_POP:    if (count != '0) state_next = S_POP;
          OP_ROTATE: if (count > CW'(1)) state_next = S_ROT;
          OP_SORT:   if (count > CW'(1)) state_next = S_PAIR_RD;
          OP_CUT: begin
            if (!count[0] && count != '0) state_next = S_PAIR_RD;
            else if (count[0] && count != CW'(DEPTH)) state_next = S_SUM_RD;
          end
          default: ;
        endcase
      end
      S_POP:      state_next = S_DONE;
      S_ROT:      state_next = S_DONE;
      S_SUM_RD:   state_next = S_SUM_ADD;
      S_SUM_ADD:  state_next = sum_last ? S_DIV : S_SUM_RD;
      S_DIV: begin
        if (dcnt == DCW'(SW - 1)) state_next = S_AVG_WR;
      end
      S_AVG_WR:   state_next = S_PAIR_RD;
      S_PAIR_RD:  state_next = S_PAIR_CMP;
      S_PAIR_CMP: state_next = swap_hit ? S_PAIR_WR : (pair_last ? S_DONE : S_PAIR_RD);
      S_PAIR_WR:  state_next = pair_last ? S_DONE : S_PAIR_RD;
      S_DONE: begin
        if (out_ready) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    out_valid = (state == S_DONE);
    addr_a    = slot_of(head, pa);
    addr_b    = slot_of(head, pb);
    we        = 1'b0;
    waddr     = slot_of(head, count);
    wdata     = pval;
    unique case (state)
      S_DISPATCH: begin
        // pop reads the head, rotate the tail
        if (op == OP_ROTATE) addr_a = slot_of(head, count - CW'(1));
        else addr_a = head;
        we = (op == OP_PUSH) && (count != CW'(DEPTH));
      end
      S_ROT: begin
        we    = 1'b1;
        waddr = head_dec;
        wdata = rd_a;
      end
      S_AVG_WR: begin
        we    = 1'b1;
        wdata = sum[31:0];
      end
      S_PAIR_CMP: begin
        we    = swap_hit;
        waddr = addr_a;
        wdata = rd_b;
      end
      S_PAIR_WR: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = tmp;
      end
      default: ;
    endcase
  end

  assign out_data = '{pop_value: pop_word, status: status_code,
                      occupancy: 5'(count), is_empty: (count == '0)};

  always_ff @(posedge clk) begin
    rd_a <= ring[addr_a];
    rd_b <= ring[addr_b];
    if (we) ring[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op          <= in_data.opcode;
            pval        <= in_data.push_value;
            pop_word    <= '0;
            status_code <= ST_OK;
          end
        end
        S_DISPATCH: begin
          pa    <= '0;
          pb    <= CW'(1);
          last  <= count - CW'(1);
          phase <= 1'b0;
          sum   <= '0;
          case (op) inside
            OP_PUSH: begin
              if (count == CW'(DEPTH)) status_code <= ST_FULL;
              else count <= count + CW'(1);
            end
            OP_POP, OP_ROTATE, OP_SORT: begin
              if (count == '0) status_code <= ST_EMPTY;
            end
            OP_CUT: begin
              if (count == '0) status_code <= ST_EMPTY;
              else if (count[0] && count == CW'(DEPTH)) status_code <= ST_FULL;
              else if (!count[0]) pb <= count - CW'(1);
            end
            default: ;
          endcase
        end
        S_POP: begin
          pop_word <= rd_a;
          head     <= head_inc;
          count    <= count - CW'(1);
        end
        S_ROT: head <= head_dec;
        S_SUM_ADD: begin
          sum  <= sum + SW'(rd_a);
          pa   <= pa + CW'(1);
          rem  <= '0;
          dcnt <= '0;
        end
        S_DIV: begin
          sum  <= {sum[SW-2:0], qbit};
          rem  <= qbit ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
          dcnt <= dcnt + DCW'(1);
        end
        S_AVG_WR: begin
          // average lands at the tail, then reverse the whole queue
          count <= count + CW'(1);
          pa    <= '0;
          pb    <= count;
          phase <= 1'b0;
        end
        S_PAIR_CMP: tmp <= rd_a;
        default: ;
      endcase
      // advance the pair: next compare for sort, next swap of a reversal for cut
      if (step && !pair_last) begin
        if (is_sort) begin
          if (pass_end) begin
            pa   <= '0;
            pb   <= CW'(1);
            last <= last - CW'(1);
          end else begin
            pa <= pa + CW'(1);
            pb <= pb + CW'(1);
          end
        end else if (!phase && !rev_more) begin
          // whole queue reversed: now reverse the back half back into order
          phase <= 1'b1;
          pa    <= count >> 1;
          pb    <= count - CW'(1);
        end else begin
          pa <= pa + CW'(1);
          pb <= pb - CW'(1);
        end
      end
    end
  end

endmodule

### bench/tb_queue_engine_with_rotate_sort.sv
// Testbench for the queue engine: random commands checked against a queue predictor.
`timescale 1ns / 1ps

module tb_queue_engine_with_rotate_sort;
  import qers_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;

  class queue_scoreboard;
    logic [31:0] words[$];
    out_item_t   pending[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Apply one command to the model queue and hold the result it should give.
    function void note_command(in_item_t it);
      out_item_t   r;
      logic [31:0] buf_w[$];
      logic [31:0] tmp;
      logic [63:0] total;
      int          n, half, j;
      r = '0;
      r.status = ST_OK;
      case (it.opcode)
        OP_PUSH: begin
          if (words.size() >= QDEPTH) r.status = ST_FULL;
          else words.push_back(it.push_value);
        end
        OP_POP: begin
          if (words.size() == 0) r.status = ST_EMPTY;
          else r.pop_value = words.pop_front();
        end
        OP_ROTATE: begin
          if (words.size() == 0) r.status = ST_EMPTY;
          else if (words.size() > 1) words.push_front(words.pop_back());
        end
        OP_SORT: begin
          if (words.size() == 0) r.status = ST_EMPTY;
          else begin
            for (int i = 1; i < words.size(); i++) begin
              tmp = words[i];
              j = i;
              while (j > 0 && words[j-1] > tmp) begin
                words[j] = words[j-1];
                j--;
              end
              words[j] = tmp;
            end
          end
        end
        OP_CUT: begin
          n = words.size();
          if (n == 0) r.status = ST_EMPTY;
          else if (n[0] && n >= QDEPTH) r.status = ST_FULL;
          else begin
            if (n[0]) begin
              total = '0;
              foreach (words[i]) total += words[i];
              words.push_back(32'(total / 64'(n)));
              n++;
            end
            half = n / 2;
            buf_w = {};
            for (int i = 0; i < half; i++) buf_w.push_back(words[n-1-i]);
            for (int i = 0; i < half; i++) buf_w.push_back(words[i]);
            words = buf_w;
          end
        end
        default: ;
      endcase
      r.occupancy = 5'(words.size());
      r.is_empty  = (words.size() == 0);
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      mismatches++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("result with nothing pending");
        return;
      end
      want = pending.pop_front();
      if (got.pop_value !== want.pop_value)
        report($sformatf("pop_value %h want %h", got.pop_value, want.pop_value));
      if (got.status !== want.status)
        report($sformatf("status %0d want %0d", got.status, want.status));
      if (got.occupancy !== want.occupancy)
        report($sformatf("occupancy %0d want %0d", got.occupancy, want.occupancy));
      if (got.is_empty !== want.is_empty)
        report($sformatf("is_empty %b want %b", got.is_empty, want.is_empty));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  queue_scoreboard sb = new();
  int sent = 0;

  queue_engine_with_rotate_sort u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(15);
      default: return $urandom();
    endcase
  endfunction

  // Hold valid across back-to-back items; drop it only for a gap.
  task automatic send_cmd(logic [2:0] op, logic [31:0] val);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, push_value: val};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command('{opcode: op, push_value: val});
    sent++;
  endtask

  // Receiver: random stalls, checked on handshake.
  initial begin
    int g;
    @(negedge rst);
    forever begin
      g = gap_len();
      if (g != 0) begin
        out_ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin
    int p;
    logic [2:0] op;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Empty-queue cases, then one entry, a full queue, sort, cut and unknown opcodes
    send_cmd(OP_POP, 32'h1234_5678);
    send_cmd(OP_ROTATE, '0);
    send_cmd(OP_SORT, '0);
    send_cmd(OP_CUT, '0);
    send_cmd(3'd5, '0);
    send_cmd(OP_PUSH, 32'hFFFF_FFFF);
    send_cmd(OP_ROTATE, '0);
    send_cmd(3'd7, 32'hAAAA_AAAA);
    for (int i = 0; i < 16; i++) send_cmd(OP_PUSH, (i % 2) ? 32'hFFFF_FFFF : 32'(i));
    send_cmd(OP_PUSH, 32'h5555_5555);
    send_cmd(OP_SORT, '0);
    send_cmd(OP_CUT, '0);
    send_cmd(OP_POP, '0);
    send_cmd(OP_CUT, '0);
    send_cmd(3'd6, '0);
    // Random part: pushes most often, then pops, rotates, sorts, cuts and a few unknown opcodes.
    while (sent < 450) begin
      p = $urandom_range(99);
      if (p < 4) op = 3'($urandom_range(7, 5));
      else if (p < 40) op = OP_PUSH;
      else if (p < 62) op = OP_POP;
      else if (p < 75) op = OP_ROTATE;
      else if (p < 87) op = OP_SORT;
      else op = OP_CUT;
      send_cmd(op, rand_word());
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
